// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is held.
`define PBDC_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("point box classifier check failed");

// Concurrent assertion that is also checked across reset.
`define PBDC_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("point box classifier reset check failed");

`endif

// ===== sv/pbdc_pkg.sv =====
// Types and constants of the point/box dynamic classifier.
package pbdc_pkg;

    localparam logic [1:0] KIND_CLEAR  = 2'd0;
    localparam logic [1:0] KIND_APPEND = 2'd1;
    localparam logic [1:0] KIND_POINT  = 2'd2;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    localparam logic [1:0] ST_POINT   = 2'd0;
    localparam logic [1:0] ST_STORED  = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_CLEARED = 2'd3;

    localparam int unsigned ADDR_W = 5;
    localparam logic [2:0] REG_RADIUS   = 3'd0;
    localparam logic [2:0] REG_MARGIN   = 3'd1;
    localparam logic [2:0] REG_SPEED    = 3'd2;
    localparam logic [2:0] REG_CLASS_ON = 3'd3;
    localparam logic [2:0] REG_SPEED_ON = 3'd4;
    localparam logic [2:0] REG_MASK     = 3'd5;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [19:0] pos_x;
        logic signed [19:0] pos_y;
        logic signed [19:0] pos_z;
        logic [15:0]        box_length;
        logic [15:0]        box_width;
        logic [15:0]        box_height;
        logic signed [15:0] yaw_cos;
        logic signed [15:0] yaw_sin;
        logic [4:0]         class_label;
        logic signed [15:0] vel_x;
        logic signed [15:0] vel_y;
    } in_item_t;

    typedef struct packed {
        logic [1:0] status;
        logic       is_dynamic;
        logic [5:0] nearest_box;
        logic       box_found;
    } out_item_t;

    typedef struct packed {
        logic [15:0] radius;
        logic [15:0] margin;
        logic [15:0] speed;
        logic        class_on;
        logic        speed_on;
        logic [31:0] mask;
    } cfg_t;

    typedef struct packed {
        logic signed [19:0] cx;
        logic signed [19:0] cy;
        logic signed [19:0] cz;
        logic [15:0]        len;
        logic [15:0]        wid;
        logic [15:0]        hgt;
        logic signed [15:0] cs;
        logic signed [15:0] sn;
        logic [4:0]         cls;
        logic signed [15:0] vx;
        logic signed [15:0] vy;
    } box_entry_t;

    typedef struct packed {
        logic clear;
        logic append;
        logic capture;
        logic empty_pt;
        logic scan_start;
        logic diff_ld;
        logic mul_ld;
        logic finish;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic empty;
        logic busy;
    } stat_t;

endpackage

// ===== sv/point_box_dynamic_classifier_unit.sv =====
// A point item runs a nearest-centre search: it reads the box table once per stored box
// through its single read port, then the nearest box is read again and tested in the
// fetch, load, multiply and test states. Clear and append items go straight to the done
// state. The finished item waits in an output register while the next is taken.
module point_box_dynamic_classifier_unit #(
    parameter int MAX_BOXES = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  pbdc_pkg::in_item_t            s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output pbdc_pkg::out_item_t           m_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pbdc_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import pbdc_pkg::*;

    cfg_t  cfg_reg;
    cmd_t  cmd;
    stat_t stat;
    logic  wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{radius: 16'd512, margin: 16'd51, speed: 16'd26,
                         class_on: 1'b1, speed_on: 1'b0, mask: 32'd321};
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_RADIUS:   cfg_reg.radius   <= pwdata[15:0];
                REG_MARGIN:   cfg_reg.margin   <= pwdata[15:0];
                REG_SPEED:    cfg_reg.speed    <= pwdata[15:0];
                REG_CLASS_ON: cfg_reg.class_on <= pwdata[0];
                REG_SPEED_ON: cfg_reg.speed_on <= pwdata[0];
                REG_MASK:     cfg_reg.mask     <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_RADIUS:   prdata = {16'd0, cfg_reg.radius};
            REG_MARGIN:   prdata = {16'd0, cfg_reg.margin};
            REG_SPEED:    prdata = {16'd0, cfg_reg.speed};
            REG_CLASS_ON: prdata = {31'd0, cfg_reg.class_on};
            REG_SPEED_ON: prdata = {31'd0, cfg_reg.speed_on};
            REG_MASK:     prdata = cfg_reg.mask;
            default:      prdata = '0;
        endcase
    end

    pbdc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_kind  (s_data.kind),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    pbdc_dp #(.MAX_BOXES(MAX_BOXES)) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cfg     (cfg_reg),
        .cmd     (cmd),
        .stat    (stat),
        .m_data  (m_data)
    );

endmodule

// ===== sv/pbdc_ctrl.sv =====
// Controller state machine of the point/box dynamic classifier.
module pbdc_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    input  logic [1:0]       s_kind,
    output logic             s_ready,
    output logic             m_valid,
    input  logic             m_ready,
    input  pbdc_pkg::stat_t  stat,
    output pbdc_pkg::cmd_t   cmd
);
    import pbdc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_FETCH, S_LOAD, S_MUL, S_TEST, S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   accept;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign accept  = s_valid && s_ready;

    always_comb begin
        cmd          = '0;
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    priority if (s_kind == KIND_CLEAR) begin
                        cmd.clear  = 1'b1;
                        state_next = S_DONE;
                    end else if (s_kind == KIND_APPEND) begin
                        cmd.append = 1'b1;
                        state_next = S_DONE;
                    end else if (s_kind == KIND_POINT) begin
                        cmd.capture = 1'b1;
                        if (stat.empty) begin
                            cmd.empty_pt = 1'b1;
                            state_next   = S_DONE;
                        end else begin
                            cmd.scan_start = 1'b1;
                            state_next     = S_SCAN;
                        end
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_SCAN:  if (!stat.busy) state_next = S_FETCH;
            S_FETCH: state_next = S_LOAD;
            S_LOAD: begin
                cmd.diff_ld = 1'b1;
                state_next  = S_MUL;
            end
            S_MUL: begin
                cmd.mul_ld = 1'b1;
                state_next = S_TEST;
            end
            S_TEST: begin
                cmd.finish = 1'b1;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// ===== sv/pbdc_dp.sv =====
// Datapath of the point/box dynamic classifier: box table, scan pipeline and box test.
module pbdc_dp #(
    parameter int MAX_BOXES = 64
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  pbdc_pkg::in_item_t   s_data,
    input  pbdc_pkg::cfg_t       cfg,
    input  pbdc_pkg::cmd_t       cmd,
    output pbdc_pkg::stat_t      stat,
    output pbdc_pkg::out_item_t  m_data
);
    import pbdc_pkg::*;

    localparam int CW = $clog2(MAX_BOXES + 1);
    localparam int IW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;

    box_entry_t mem [MAX_BOXES];
    box_entry_t rd_data_reg;
    logic [IW-1:0] rd_addr;

    logic [CW-1:0] count_reg;
    logic          full;
    logic          scan_active_reg;
    logic [IW-1:0] idx_reg, rd_idx_reg, sq_idx_reg, best_idx_reg;
    logic          rd_v_reg, sq_v_reg;
    logic          scan_last;

    logic signed [19:0] px_reg, py_reg, pz_reg;
    logic signed [20:0] sdx, sdy, sdz;
    logic [41:0]        sqx_reg, sqy_reg, sqz_reg;
    logic [43:0]        sq_dist, best_d_reg;

    logic signed [20:0] dx_reg, dy_reg, dz_reg;
    logic signed [36:0] p_cx_reg, p_sy_reg, p_cy_reg, p_sx_reg;
    logic [31:0]        vx2_reg, vy2_reg, r2_reg, th2_reg;
    logic signed [37:0] lx, ly;
    logic [38:0]        lx2, ly2;
    logic [39:0]        lim_l, lim_w;
    logic [21:0]        dz2;
    logic [17:0]        m2, lim_h;
    logic [32:0]        v2;
    logic               dyn;

    out_item_t res_reg, m_data_reg;

    assign full      = (count_reg == CW'(MAX_BOXES));
    assign scan_last = (CW'(idx_reg) + CW'(1) == count_reg);
    assign rd_addr   = scan_active_reg ? idx_reg : best_idx_reg;
    assign stat.empty = (count_reg == '0);
    assign stat.busy  = scan_active_reg || rd_v_reg || sq_v_reg;
    assign m_data     = m_data_reg;

    assign sdx  = 21'(px_reg) - 21'(rd_data_reg.cx);
    assign sdy  = 21'(py_reg) - 21'(rd_data_reg.cy);
    assign sdz  = 21'(pz_reg) - 21'(rd_data_reg.cz);
    assign sq_dist = 44'(sqx_reg) + 44'(sqy_reg) + 44'(sqz_reg);

    // Box test in the box frame; both sides are scaled by two so the half sizes stay exact.
    assign lx    = 38'(p_cx_reg) + 38'(p_sy_reg);
    assign ly    = 38'(p_cy_reg) - 38'(p_sx_reg);
    assign lx2   = {(lx[37] ? 38'(-lx) : lx), 1'b0};
    assign ly2   = {(ly[37] ? 38'(-ly) : ly), 1'b0};
    assign dz2   = {(dz_reg[20] ? 21'(-dz_reg) : dz_reg), 1'b0};
    assign m2    = {1'b0, cfg.margin, 1'b0};
    assign lim_h = 18'(rd_data_reg.hgt) + m2;
    assign lim_l = {8'd0, 18'(rd_data_reg.len) + m2, 14'd0};
    assign lim_w = {8'd0, 18'(rd_data_reg.wid) + m2, 14'd0};
    assign v2    = 33'(vx2_reg) + 33'(vy2_reg);

    always_comb begin
        dyn = (best_d_reg <= 44'(r2_reg));
        if (cfg.class_on && !cfg.mask[rd_data_reg.cls]) dyn = 1'b0;
        if (cfg.speed_on && (v2 < 33'(th2_reg))) dyn = 1'b0;
        if (40'(lx2) > lim_l || 40'(ly2) > lim_w || dz2 > 22'(lim_h)) dyn = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (cmd.append && !full) begin
            mem[count_reg[IW-1:0]] <= '{
                cx: s_data.pos_x, cy: s_data.pos_y, cz: s_data.pos_z,
                len: s_data.box_length, wid: s_data.box_width,
                hgt: s_data.box_height, cs: s_data.yaw_cos, sn: s_data.yaw_sin,
                cls: s_data.class_label, vx: s_data.vel_x, vy: s_data.vel_y};
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            px_reg <= s_data.pos_x;
            py_reg <= s_data.pos_y;
            pz_reg <= s_data.pos_z;
        end
        rd_idx_reg <= idx_reg;
        sq_idx_reg <= rd_idx_reg;
        sqx_reg    <= 42'(sdx * sdx);
        sqy_reg    <= 42'(sdy * sdy);
        sqz_reg    <= 42'(sdz * sdz);
        if (sq_v_reg && (sq_idx_reg == '0 || sq_dist < best_d_reg)) begin
            best_d_reg   <= sq_dist;
            best_idx_reg <= sq_idx_reg;
        end
        if (cmd.diff_ld) begin
            dx_reg <= sdx;
            dy_reg <= sdy;
            dz_reg <= sdz;
        end
        if (cmd.mul_ld) begin
            p_cx_reg <= 37'(rd_data_reg.cs * dx_reg);
            p_sy_reg <= 37'(rd_data_reg.sn * dy_reg);
            p_cy_reg <= 37'(rd_data_reg.cs * dy_reg);
            p_sx_reg <= 37'(rd_data_reg.sn * dx_reg);
            vx2_reg  <= 32'(rd_data_reg.vx * rd_data_reg.vx);
            vy2_reg  <= 32'(rd_data_reg.vy * rd_data_reg.vy);
            r2_reg   <= 32'(cfg.radius) * 32'(cfg.radius);
            th2_reg  <= 32'(cfg.speed) * 32'(cfg.speed);
        end
        priority if (cmd.clear) begin
            res_reg <= '{status: ST_CLEARED, default: '0};
        end else if (cmd.append) begin
            res_reg <= '{status: (full ? ST_FULL : ST_STORED), default: '0};
        end else if (cmd.empty_pt) begin
            res_reg <= '{status: ST_POINT, default: '0};
        end else if (cmd.finish) begin
            res_reg <= '{status: ST_POINT, is_dynamic: dyn,
                         nearest_box: 6'(best_idx_reg), box_found: 1'b1};
        end
        if (cmd.out_load) m_data_reg <= res_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg       <= '0;
            scan_active_reg <= 1'b0;
            idx_reg         <= '0;
            rd_v_reg        <= 1'b0;
            sq_v_reg        <= 1'b0;
        end else begin
            if (cmd.clear) begin
                count_reg <= '0;
            end else if (cmd.append && !full) begin
                count_reg <= count_reg + CW'(1);
            end
            if (cmd.scan_start) begin
                scan_active_reg <= 1'b1;
                idx_reg         <= '0;
            end else if (scan_active_reg) begin
                if (scan_last) scan_active_reg <= 1'b0;
                idx_reg <= idx_reg + IW'(1);
            end
            rd_v_reg <= scan_active_reg;
            sq_v_reg <= rd_v_reg;
        end
    end

endmodule

// ===== sv/pbdc_chk.sv =====
// Port checker of the point/box dynamic classifier and its bind.
`include "assert_macros.svh"

module pbdc_chk (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_valid,
    input logic                 s_ready,
    input logic                 m_valid,
    input logic                 m_ready,
    input pbdc_pkg::out_item_t  m_data
);
    import pbdc_pkg::*;

    `PBDC_ASSERT_ALWAYS(a_no_item_after_reset, aclk, !aresetn |=> !m_valid)
    `PBDC_ASSERT(a_hold_item, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_data))
    `PBDC_ASSERT(a_dyn_needs_box, aclk, aresetn, m_valid && !m_data.box_found |-> !m_data.is_dynamic)
    `PBDC_ASSERT(a_table_item_clean, aclk, aresetn, m_valid && m_data.status != ST_POINT |-> !m_data.box_found && !m_data.is_dynamic && m_data.nearest_box == 6'd0)

endmodule

bind point_box_dynamic_classifier_unit pbdc_chk u_pbdc_chk (.*);

// ===== dv/testbench.sv =====
// Self-checking testbench for the point/box dynamic classifier unit.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import pbdc_pkg::*;

    localparam int NBOX = 64;
    localparam int WATCHDOG = 20000;

    typedef struct {
        logic signed [19:0] cx, cy, cz;
        logic [15:0] len, wid, hgt;
        logic signed [15:0] cs, sn;
        logic [4:0] cls;
        logic signed [15:0] vx, vy;
    } box_t;

    // Predicts each result from its own copy of the table and the registers.
    class classifier_scoreboard;
        box_t tbl[NBOX];
        int unsigned count;
        logic [15:0] radius, margin, speed;
        logic class_on, speed_on;
        logic [31:0] mask;
        out_item_t pending[$];
        int errors;

        function new();
            count = 0; radius = 512; margin = 51; speed = 26;
            class_on = 1; speed_on = 0; mask = 321; errors = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] v);
            case (idx)
                REG_RADIUS:   radius = v[15:0];
                REG_MARGIN:   margin = v[15:0];
                REG_SPEED:    speed = v[15:0];
                REG_CLASS_ON: class_on = v[0];
                REG_SPEED_ON: speed_on = v[0];
                REG_MASK:     mask = v;
                default: ;
            endcase
        endfunction

        function automatic logic point_in_box(box_t b, in_item_t p);
            longint dx, dy, dz, lx, ly, m2;
            dx = longint'(p.pos_x) - longint'(b.cx);
            dy = longint'(p.pos_y) - longint'(b.cy);
            dz = longint'(p.pos_z) - longint'(b.cz);
            lx = longint'(b.cs) * dx + longint'(b.sn) * dy;
            ly = longint'(b.cs) * dy - longint'(b.sn) * dx;
            if (lx < 0) lx = -lx;
            if (ly < 0) ly = -ly;
            if (dz < 0) dz = -dz;
            m2 = 2 * longint'(margin);
            return (2 * lx <= ((longint'(b.len) + m2) << 14)) &&
                   (2 * ly <= ((longint'(b.wid) + m2) << 14)) &&
                   (2 * dz <= longint'(b.hgt) + m2);
        endfunction

        function void note_item(in_item_t it);
            out_item_t r;
            longint dx, dy, dz, d, best_d, v2;
            int best;
            logic dyn;
            r = '0;
            case (it.kind)
                KIND_CLEAR: begin
                    count = 0;
                    r.status = ST_CLEARED;
                end
                KIND_APPEND: begin
                    if (count >= NBOX) begin
                        r.status = ST_FULL;
                    end else begin
                        tbl[count] = '{it.pos_x, it.pos_y, it.pos_z, it.box_length,
                            it.box_width, it.box_height, it.yaw_cos, it.yaw_sin,
                            it.class_label, it.vel_x, it.vel_y};
                        count++;
                        r.status = ST_STORED;
                    end
                end
                KIND_POINT: begin
                    r.status = ST_POINT;
                    if (count != 0) begin
                        best = 0; best_d = 0;
                        for (int i = 0; i < count; i++) begin
                            dx = longint'(it.pos_x) - longint'(tbl[i].cx);
                            dy = longint'(it.pos_y) - longint'(tbl[i].cy);
                            dz = longint'(it.pos_z) - longint'(tbl[i].cz);
                            d = dx * dx + dy * dy + dz * dz;
                            if (i == 0 || d < best_d) begin
                                best_d = d; best = i;
                            end
                        end
                        r.nearest_box = best[5:0];
                        r.box_found = 1'b1;
                        dyn = best_d <= longint'(radius) * longint'(radius);
                        if (dyn && class_on && !mask[tbl[best].cls]) dyn = 0;
                        if (dyn && speed_on) begin
                            v2 = longint'(tbl[best].vx) * tbl[best].vx +
                                 longint'(tbl[best].vy) * tbl[best].vy;
                            if (v2 < longint'(speed) * longint'(speed)) dyn = 0;
                        end
                        if (dyn && !point_in_box(tbl[best], it)) dyn = 0;
                        r.is_dynamic = dyn;
                    end
                end
                default: return;
            endcase
            pending.insert(pending.size(), r);
        endfunction

        task check_result(out_item_t got);
            out_item_t w;
            if (pending.size() == 0) begin
                report("result with nothing expected", got, '0);
                return;
            end
            w = pending.pop_front();
            if (got.status !== w.status) report("status", got, w);
            if (got.is_dynamic !== w.is_dynamic) report("is_dynamic", got, w);
            if (got.nearest_box !== w.nearest_box) report("nearest_box", got, w);
            if (got.box_found !== w.box_found) report("box_found", got, w);
        endtask

        task report(string what, out_item_t got, out_item_t want);
            errors++;
            $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
        endtask
    endclass

    logic aclk = 0, aresetn = 0;
    logic s_valid = 0, s_ready, m_valid, m_ready = 0;
    in_item_t s_data = '0;
    out_item_t m_data;
    logic psel = 0, penable = 0, pwrite = 0, pready;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0, prdata;

    classifier_scoreboard sb = new();
    int idle_cycles = 0;
    bit hold_off = 0;
    bit timed_out = 0;
    in_item_t box_pool[$];

    point_box_dynamic_classifier_unit #(.MAX_BOXES(NBOX)) i_dut (.*);

    initial forever #5 aclk = ~aclk;

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic in_item_t rand_item();
        logic [191:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        return raw[$bits(in_item_t)-1:0];
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [31:0] v);
        @(posedge aclk);
        psel <= 1; pwrite <= 1; paddr <= ADDR_W'(idx) << 2; pwdata <= v;
        @(posedge aclk);
        penable <= 1;
        @(posedge aclk);
        psel <= 0; penable <= 0; pwrite <= 0;
        sb.set_reg(idx, v);
    endtask

    // Valid stays high straight into the next item when there is no gap.
    task automatic send(in_item_t it);
        int n;
        s_valid <= 1; s_data <= it;
        do @(posedge aclk); while (!s_ready);
        sb.note_item(it);
        n = gap_len();
        if (n > 0) begin
            s_valid <= 0;
            repeat (n) @(posedge aclk);
        end
    endtask

    function automatic in_item_t rand_box(int spread);
        in_item_t it;
        it = rand_item();
        it.kind = KIND_APPEND;
        it.pos_x = 20'(int'($urandom_range(0, 2 * spread)) - spread);
        it.pos_y = 20'(int'($urandom_range(0, 2 * spread)) - spread);
        it.pos_z = 20'(int'($urandom_range(0, spread)) - spread / 2);
        it.box_length = 16'($urandom_range(0, 1500));
        it.box_width = 16'($urandom_range(0, 800));
        it.box_height = 16'($urandom_range(0, 600));
        it.yaw_cos = 16'(int'($urandom_range(0, 32768)) - 16384);
        it.yaw_sin = 16'(int'($urandom_range(0, 32768)) - 16384);
        if ($urandom_range(0, 3) == 0) begin
            it.yaw_cos = 16'sd16384; it.yaw_sin = '0;
        end
        return it;
    endfunction

    // Usually a point near a box already in the table, so that most reach the box test.
    function automatic in_item_t near_point(int spread);
        in_item_t it, b;
        it = rand_item();
        it.kind = KIND_POINT;
        if (box_pool.size() != 0 && $urandom_range(0, 4) != 0) begin
            b = box_pool[$urandom_range(0, box_pool.size() - 1)];
            it.pos_x = 20'(int'(b.pos_x) + int'($urandom_range(0, 800)) - 400);
            it.pos_y = 20'(int'(b.pos_y) + int'($urandom_range(0, 800)) - 400);
            it.pos_z = 20'(int'(b.pos_z) + int'($urandom_range(0, 400)) - 200);
        end else if ($urandom_range(0, 1) == 0) begin
            it.pos_x = 20'(int'($urandom_range(0, 2 * spread)) - spread);
        end
        return it;
    endfunction

    task automatic drain();
        s_valid <= 0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    task automatic directed();
        in_item_t it;
        it = '0;
        it.kind = KIND_POINT; send(it);         // empty table
        it.kind = KIND_CLEAR; send(it);
        it = '0; it.kind = KIND_APPEND; it.box_length = 16'd512; it.box_width = 16'd256;
        it.box_height = 16'd256; it.yaw_cos = 16'sd16384; it.class_label = 5'd0; send(it);
        it.kind = KIND_POINT; send(it);         // centre of a box
        it.pos_x = 20'sd400; send(it);
        it.pos_x = 20'h80000; it.pos_y = 20'h7FFFF; it.pos_z = 20'h80000; send(it);
        it = '1; it.kind = KIND_APPEND; it.class_label = 5'd6; send(it);
        it = '0; it.kind = KIND_APPEND; it.pos_x = -20'sd20; it.yaw_cos = -16'sd16384;
        it.yaw_sin = 16'sd16384; it.box_length = 16'hFFFF; it.box_width = 16'hFFFF;
        it.box_height = 16'hFFFF; it.class_label = 5'd31; it.vel_x = 16'sh8000;
        it.vel_y = 16'sh7FFF; send(it);
        it.kind = KIND_POINT; it.pos_x = -20'sd10; send(it);    // tie-ish position
        it.kind = KIND_UNUSED; send(it);                         // ignored kind
        it.kind = KIND_POINT; it.pos_x = 20'sd10; send(it);
        // Fill the table past its capacity.
        for (int i = 0; i < NBOX + 2; i++) begin
            it = rand_box(3000); send(it);
        end
        it = near_point(3000); send(it);
        it.kind = KIND_CLEAR; send(it);
    endtask

    task automatic random_phase(int n);
        in_item_t it;
        int spread;
        spread = $urandom_range(0, 1) ? 2000 : 200000;
        box_pool.delete();
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 19))
                0: begin
                    it = '0; it.kind = KIND_CLEAR; box_pool.delete();
                end
                1, 2, 3, 4, 5: begin
                    it = rand_box(spread);
                    if (box_pool.size() < NBOX) box_pool.insert(box_pool.size(), it);
                end
                6: it = rand_item();
                default: it = near_point(spread);
            endcase
            if (it.kind == KIND_CLEAR) box_pool.delete();
            send(it);
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_data);
        if ((s_valid && s_ready) || (m_valid && m_ready) || psel || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG && !timed_out) begin
            timed_out = 1;
            $display("testbench: FAIL");
            $finish;
        end
    end

    // Receiver: random stalls, plus one long hold-off when asked for.
    initial begin
        int n;
        @(posedge aresetn);
        forever begin
            if (hold_off) begin
                m_ready <= 0;
                repeat (600) @(posedge aclk);
                hold_off = 0;
            end
            m_ready <= 1;
            @(posedge aclk);
            if ($urandom_range(0, 3) == 0) begin
                n = gap_len();
                if (n > 0) begin
                    m_ready <= 0;
                    repeat (n) @(posedge aclk);
                end
            end
        end
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        directed();
        drain();
        hold_off = 1;
        random_phase(150);
        drain();
        write_reg(REG_RADIUS, 16'hFFFF); write_reg(REG_MARGIN, 0);
        write_reg(REG_SPEED, 0); write_reg(REG_CLASS_ON, 0);
        write_reg(REG_SPEED_ON, 1); write_reg(REG_MASK, 32'hFFFF_FFFF);
        random_phase(160);
        drain();
        write_reg(REG_RADIUS, 0); write_reg(REG_MARGIN, 16'hFFFF);
        write_reg(REG_SPEED, 16'hFFFF); write_reg(REG_CLASS_ON, 1);
        write_reg(REG_MASK, 0);
        random_phase(120);
        drain();
        for (int k = 0; k < 3; k++) begin
            write_reg(REG_RADIUS, $urandom_range(0, 3000));
            write_reg(REG_MARGIN, $urandom_range(0, 300));
            write_reg(REG_SPEED, $urandom_range(0, 2000));
            write_reg(REG_CLASS_ON, $urandom_range(0, 1));
            write_reg(REG_SPEED_ON, $urandom_range(0, 1));
            write_reg(REG_MASK, $urandom);
            random_phase(110);
            drain();
        end
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+sv
sv/pbdc_pkg.sv
sv/pbdc_ctrl.sv
sv/pbdc_dp.sv
sv/point_box_dynamic_classifier_unit.sv
sv/pbdc_chk.sv
dv/testbench.sv
